>>> design/wcct_pkg.sv
// ----------------------------------------------------------------------------
// wcct_pkg: shared types and constants of the wall clock timekeeper
// Beat payload structs, error codes, result kinds and the command characters.
// ----------------------------------------------------------------------------
package wcct_pkg;

  // Command store depth and the saturation value of the byte count.
  localparam int unsigned CMD_DEPTH = 12;
  localparam int unsigned CNT_W     = $clog2(CMD_DEPTH + 2);
  localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(CMD_DEPTH + 1);

  // Lengths of the two command forms.
  localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(3);
  localparam logic [CNT_W-1:0] LEN_SET   = CNT_W'(12);

  // Byte positions inside a command.
  localparam int unsigned POS_PCT  = 0;
  localparam int unsigned POS_W    = 1;
  localparam int unsigned POS_OP   = 2;
  localparam int unsigned POS_SP   = 3;
  localparam int unsigned POS_H10  = 4;
  localparam int unsigned POS_H1   = 5;
  localparam int unsigned POS_C0   = 6;
  localparam int unsigned POS_M10  = 7;
  localparam int unsigned POS_M1   = 8;
  localparam int unsigned POS_C1   = 9;
  localparam int unsigned POS_S10  = 10;
  localparam int unsigned POS_S1   = 11;

  // ASCII characters of the command syntax.
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Time wrap limits.
  localparam logic [4:0] HOURS_MAX = 5'd23;
  localparam logic [5:0] MINS_MAX  = 6'd59;
  localparam logic [5:0] SECS_MAX  = 6'd59;
  localparam logic [6:0] HOURS_LIM = 7'd24;
  localparam logic [6:0] MS_LIM    = 7'd60;

  // Operation codes of an input beat.
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam logic KIND_TIME  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_PREFIX  = 3'd1;
  localparam logic [2:0] ERR_LENGTH  = 3'd2;
  localparam logic [2:0] ERR_FORMAT  = 3'd3;
  localparam logic [2:0] ERR_DIGIT   = 3'd4;
  localparam logic [2:0] ERR_RANGE   = 3'd5;
  localparam logic [2:0] ERR_UNKNOWN = 3'd6;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_byte;
    logic       last_char;
  } wcct_in_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] error_code;
    logic [4:0] hours_out;
    logic [5:0] minutes_out;
    logic [5:0] seconds_out;
  } wcct_out_t;

endpackage

>>> design/wall_clock_command_timekeeper_unit.sv
// ----------------------------------------------------------------------------
// wall_clock_command_timekeeper_unit: hh:mm:ss clock run by text commands
// Collects command bytes, decodes %WR, %WS hh:mm:ss and %WT, and advances
// the time on one-second ticks, giving a time display or an error status.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  wcct_in_t  (operation, byte, last)
//   out_     output     out_valid/out_stall wcct_out_t (kind, code, h, m, s)
//
// One beat is taken per cycle while in_stall is low. A beat is registered at
// acceptance, then decoded or applied to the time once the output register can
// take its result, and any result is held in the output register.
// Throughput is set by the single output register: while it holds a stalled
// result, the input register holds its beat and in_stall rises.
// Reset clears the time, the running flag, the byte count and both valids.
// ----------------------------------------------------------------------------
module wall_clock_command_timekeeper_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wcct_pkg::wcct_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wcct_pkg::wcct_out_t out_data
);
  import wcct_pkg::*;

  // Input register stage.
  logic     s1_valid_r, s1_valid_nxt;
  wcct_in_t s1_data_r;

  // Clock state.
  logic [4:0]       hours_r,   hours_nxt;
  logic [5:0]       minutes_r, minutes_nxt;
  logic [5:0]       seconds_r, seconds_nxt;
  logic             running_r, running_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;

  // Bytes of the command being collected; never reset, each entry is
  // written before the decode of the same command reads it.
  logic [7:0] cmd_mem_r [CMD_DEPTH];

  // Output register.
  logic      out_valid_r;
  wcct_out_t out_data_r;

  // Result of the beat in the input register.
  logic      res_valid;
  wcct_out_t res_data;

  logic in_accept;
  logic s1_adv;
  logic s1_fire;

  // The command as the decoder sees it: stored bytes, with the beat in the
  // input register standing in at its own position.
  logic [7:0]       view [CMD_DEPTH];
  logic [CNT_W-1:0] cmd_len;
  logic [7:0]       op_byte;
  logic             prefix_ok;
  logic             length_ok;
  logic             format_ok;
  logic             digits_ok;
  logic [6:0]       hh_val, mm_val, ss_val;

  // The decode stage moves whenever the output register is empty or drains.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Assemble the command view and check its pieces.
  always_comb begin
    for (int i = 0; i < CMD_DEPTH; i++) begin
      view[i] = (byte_count_r == CNT_W'(i)) ? s1_data_r.char_byte : cmd_mem_r[i];
    end
    cmd_len   = (byte_count_r < COUNT_SAT) ? byte_count_r + CNT_W'(1) : byte_count_r;
    op_byte   = view[POS_OP];
    prefix_ok = (cmd_len >= LEN_SHORT) && (view[POS_PCT] == CH_PCT) &&
                (view[POS_W] == CH_W);
    length_ok = (op_byte == CH_S) ? (cmd_len == LEN_SET) : (cmd_len == LEN_SHORT);
    format_ok = (view[POS_SP] == CH_SPACE) && (view[POS_C0] == CH_COLON) &&
                (view[POS_C1] == CH_COLON);
    digits_ok = 1'b1;
    for (int i = 0; i < CMD_DEPTH; i++) begin
      if (i == POS_H10 || i == POS_H1 || i == POS_M10 || i == POS_M1 ||
          i == POS_S10 || i == POS_S1) begin
        if (view[i] < CH_ZERO || view[i] > CH_NINE) begin
          digits_ok = 1'b0;
        end
      end
    end
    // For a digit byte the low nibble is its value.
    hh_val = 7'(view[POS_H10][3:0]) * 7'd10 + 7'(view[POS_H1][3:0]);
    mm_val = 7'(view[POS_M10][3:0]) * 7'd10 + 7'(view[POS_M1][3:0]);
    ss_val = 7'(view[POS_S10][3:0]) * 7'd10 + 7'(view[POS_S1][3:0]);
  end

  // Apply the beat to the clock state and form its result.
  always_comb begin
    hours_nxt      = hours_r;
    minutes_nxt    = minutes_r;
    seconds_nxt    = seconds_r;
    running_nxt    = running_r;
    byte_count_nxt = byte_count_r;
    res_valid      = 1'b0;
    res_data       = '0;

    if (s1_fire) begin
      if (s1_data_r.operation == OP_TICK) begin
        // A stopped clock ignores ticks.
        if (running_r) begin
          if (seconds_r == SECS_MAX) begin
            seconds_nxt = '0;
            if (minutes_r == MINS_MAX) begin
              minutes_nxt = '0;
              hours_nxt   = (hours_r == HOURS_MAX) ? '0 : hours_r + 5'd1;
            end else begin
              minutes_nxt = minutes_r + 6'd1;
            end
          end else begin
            seconds_nxt = seconds_r + 6'd1;
          end
          res_valid = 1'b1;
        end
      end else begin
        byte_count_nxt = cmd_len;
        if (s1_data_r.last_char) begin
          byte_count_nxt = '0;
          res_valid      = 1'b1;
          // Checks run in a fixed order; the first failure gives the code.
          priority if (!prefix_ok) begin
            res_data.error_code = ERR_PREFIX;
          end else if (!length_ok) begin
            res_data.error_code = ERR_LENGTH;
          end else if (op_byte == CH_T) begin
            running_nxt = 1'b0;
            res_valid   = 1'b0;
          end else if (op_byte == CH_R) begin
            hours_nxt   = '0;
            minutes_nxt = '0;
            seconds_nxt = '0;
            running_nxt = 1'b1;
          end else if (op_byte != CH_S) begin
            res_data.error_code = ERR_UNKNOWN;
          end else if (!format_ok) begin
            res_data.error_code = ERR_FORMAT;
          end else if (!digits_ok) begin
            res_data.error_code = ERR_DIGIT;
          end else if (hh_val >= HOURS_LIM || mm_val >= MS_LIM || ss_val >= MS_LIM) begin
            res_data.error_code = ERR_RANGE;
          end else begin
            hours_nxt   = hh_val[4:0];
            minutes_nxt = mm_val[5:0];
            seconds_nxt = ss_val[5:0];
            running_nxt = 1'b1;
          end
        end
      end

      if (res_data.error_code != ERR_NONE) begin
        res_data.result_kind = KIND_ERROR;
      end else begin
        res_data.result_kind = KIND_TIME;
        res_data.hours_out   = hours_nxt;
        res_data.minutes_out = minutes_nxt;
        res_data.seconds_out = seconds_nxt;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      hours_r      <= '0;
      minutes_r    <= '0;
      seconds_r    <= '0;
      running_r    <= 1'b0;
      byte_count_r <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      hours_r      <= hours_nxt;
      minutes_r    <= minutes_nxt;
      seconds_r    <= seconds_nxt;
      running_r    <= running_nxt;
      byte_count_r <= byte_count_nxt;
      if (s1_adv) begin
        out_valid_r <= s1_fire && res_valid;
      end
    end
  end

  // Payload registers and the command store.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_fire && res_valid) begin
      out_data_r <= res_data;
    end
    if (s1_fire && s1_data_r.operation == OP_CHAR &&
        byte_count_r < CNT_W'(CMD_DEPTH)) begin
      cmd_mem_r[byte_count_r] <= s1_data_r.char_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A time display carries no error code and a legal time.
  a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == KIND_TIME |->
      out_data_r.error_code == ERR_NONE && out_data_r.hours_out <= HOURS_MAX &&
      out_data_r.minutes_out <= MINS_MAX && out_data_r.seconds_out <= SECS_MAX)
    else $error("time display with an error code or an illegal time");

  // An error status carries a real code and zero time fields.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_kind == KIND_ERROR |->
      out_data_r.error_code != ERR_NONE && out_data_r.hours_out == '0 &&
      out_data_r.minutes_out == '0 && out_data_r.seconds_out == '0)
    else $error("error status with a time or without a code");

  // The byte count never passes its saturation value.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= COUNT_SAT)
    else $error("byte count beyond saturation");

  // A tick on a running clock always gives a display in the next cycle.
  a_tick_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_data_r.operation == OP_TICK && running_r |=>
      out_valid_r && out_data_r.result_kind == KIND_TIME)
    else $error("tick on a running clock gave no display");

endmodule

>>> tb/tb_wall_clock_command_timekeeper_unit.sv
// ----------------------------------------------------------------------------
// tb_wall_clock_command_timekeeper_unit: self-checking bench of the timekeeper
// Feeds command bytes and one-second ticks through the input channel, predicts
// every time display and error status in a behavioral copy of the clock, and
// compares each result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_wall_clock_command_timekeeper_unit;
  import wcct_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // The slowest correct run, even with gaps on both sides, stays far below
  // this limit, which leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  // Extra wait after the last owed result has come out, to catch strays.
  localparam int unsigned SETTLE_CYCLES = 8;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  wcct_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  wcct_out_t out_data;

  // Idling on both channels is switched by the stimulus phase.
  bit          idling_on = 1'b1;
  int unsigned beats_sent;
  int unsigned fail_count;
  int unsigned cycle_count;

  // Behavioral copy of the clock: time, running flag and the command buffer.
  logic [4:0]  mdl_hours;
  logic [5:0]  mdl_minutes;
  logic [5:0]  mdl_seconds;
  bit          mdl_running;
  int unsigned cmd_len;
  logic [7:0]  cmd_store [CMD_DEPTH];

  // Displays and error statuses that the block still owes, oldest first.
  wcct_out_t readouts_due[$];

  wall_clock_command_timekeeper_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic wcct_out_t time_readout();
    wcct_out_t r;
    r             = '0;
    r.result_kind = KIND_TIME;
    r.error_code  = ERR_NONE;
    r.hours_out   = mdl_hours;
    r.minutes_out = mdl_minutes;
    r.seconds_out = mdl_seconds;
    return r;
  endfunction

  function automatic wcct_out_t error_readout(input logic [2:0] code);
    wcct_out_t r;
    r             = '0;
    r.result_kind = KIND_ERROR;
    r.error_code  = code;
    return r;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int unsigned two_digits(input int unsigned pos);
    return (int'(cmd_store[pos]) - int'(CH_ZERO)) * 10
         + (int'(cmd_store[pos + 1]) - int'(CH_ZERO));
  endfunction

  // Applies one accepted beat to the clock copy and queues what it shows.
  function automatic void model_timekeeper(input wcct_in_t beat);
    int unsigned len;
    int unsigned hh;
    int unsigned mm;
    int unsigned ss;
    logic [7:0]  op;
    if (beat.operation == OP_TICK) begin
      // A stopped clock ignores ticks entirely.
      if (mdl_running) begin
        mdl_seconds = (mdl_seconds == SECS_MAX) ? 6'd0 : mdl_seconds + 6'd1;
        if (mdl_seconds == 6'd0) begin
          mdl_minutes = (mdl_minutes == MINS_MAX) ? 6'd0 : mdl_minutes + 6'd1;
          if (mdl_minutes == 6'd0)
            mdl_hours = (mdl_hours == HOURS_MAX) ? 5'd0 : mdl_hours + 5'd1;
        end
        readouts_due.push_back(time_readout());
      end
    end else begin
      // Bytes past the store depth are counted but dropped.
      if (cmd_len < CMD_DEPTH) cmd_store[cmd_len] = beat.char_byte;
      if (cmd_len < COUNT_SAT) cmd_len++;
      if (beat.last_char) begin
        len     = cmd_len;
        cmd_len = 0;
        // The checks below short-circuit, so only bytes of this command are read.
        if (len < LEN_SHORT || cmd_store[POS_PCT] != CH_PCT || cmd_store[POS_W] != CH_W) begin
          readouts_due.push_back(error_readout(ERR_PREFIX));
        end else begin
          op = cmd_store[POS_OP];
          if (len != ((op == CH_S) ? LEN_SET : LEN_SHORT)) begin
            readouts_due.push_back(error_readout(ERR_LENGTH));
          end else if (op == CH_T) begin
            mdl_running = 1'b0;
          end else if (op == CH_R) begin
            mdl_hours   = '0;
            mdl_minutes = '0;
            mdl_seconds = '0;
            mdl_running = 1'b1;
            readouts_due.push_back(time_readout());
          end else if (op != CH_S) begin
            readouts_due.push_back(error_readout(ERR_UNKNOWN));
          end else if (cmd_store[POS_SP] != CH_SPACE || cmd_store[POS_C0] != CH_COLON ||
                       cmd_store[POS_C1] != CH_COLON) begin
            readouts_due.push_back(error_readout(ERR_FORMAT));
          end else if (!is_digit(cmd_store[POS_H10]) || !is_digit(cmd_store[POS_H1]) ||
                       !is_digit(cmd_store[POS_M10]) || !is_digit(cmd_store[POS_M1]) ||
                       !is_digit(cmd_store[POS_S10]) || !is_digit(cmd_store[POS_S1])) begin
            readouts_due.push_back(error_readout(ERR_DIGIT));
          end else begin
            hh = two_digits(POS_H10);
            mm = two_digits(POS_M10);
            ss = two_digits(POS_S10);
            if (hh >= HOURS_LIM || mm >= MS_LIM || ss >= MS_LIM) begin
              readouts_due.push_back(error_readout(ERR_RANGE));
            end else begin
              mdl_hours   = 5'(hh);
              mdl_minutes = 6'(mm);
              mdl_seconds = 6'(ss);
              mdl_running = 1'b1;
              readouts_due.push_back(time_readout());
            end
          end
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Sends one beat and returns at the edge that accepts it. Valid stays high
  // on return, so the next call can present its beat back to back; the
  // caller that wants the channel quiet lowers valid itself.
  task automatic send_beat(input wcct_in_t beat);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    model_timekeeper(beat);
  endtask

  // Ticks carry random byte and last fields, which the block must ignore.
  task automatic send_tick();
    send_beat('{operation: OP_TICK, char_byte: 8'($urandom()), last_char: 1'($urandom())});
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_tick();
  endtask

  // Sends a whole command; with mix_ticks set, ticks may land between bytes.
  task automatic send_cmd(input byte_q_t bytes, input bit mix_ticks = 1'b0);
    foreach (bytes[i]) begin
      if (mix_ticks && i != 0 && $urandom_range(0, 19) == 0) send_tick();
      send_beat('{operation: OP_CHAR, char_byte: bytes[i], last_char: (i == bytes.size() - 1)});
    end
  endtask

  function automatic byte_q_t text_bytes(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_text(input string s);
    send_cmd(text_bytes(s));
  endtask

  // Picks a field value with the extremes favored.
  function automatic int unsigned field_value(input int unsigned max);
    case ($urandom_range(0, 3))
      0:       return max;
      1:       return 0;
      default: return $urandom_range(0, max);
    endcase
  endfunction

  function automatic string set_text(input int unsigned hh, mm, ss);
    return $sformatf("%%WS %02d:%02d:%02d", hh, mm, ss);
  endfunction

  // Lowers valid and waits until every owed result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset the clock is stopped: ticks and a stop show nothing.
  task automatic test_stopped_clock();
    send_ticks(2);
    send_text("%WT");
    send_tick();
  endtask

  // Starting, ticking, wrapping at every boundary, restarting and stopping.
  task automatic test_start_and_wrap();
    send_text("%WR");
    send_ticks(2);
    send_text(set_text(10, 59, 59));
    send_tick();
    send_text(set_text(23, 59, 58));
    send_ticks(2);
    // Start while running simply rewrites the time.
    send_text("%WR");
    send_text("%WT");
    send_tick();
    send_text("%WT");
    send_text(set_text(0, 0, 0));
  endtask

  // Every error code, plus the odd cases of the command buffer.
  task automatic test_command_errors();
    byte_q_t cmd;
    send_text("%");
    send_text("%W");
    send_text("XWR");
    send_text("%XR");
    send_text("%WR!");
    send_text("%WS");
    send_text("%WSx12:34:56");
    send_text("%WS 12-34:56");
    send_text("%WS 12:34;56");
    send_text("%WS 1a:34:56");
    send_text("%WS 12:34:5:");
    send_text("%WS 24:00:00");
    send_text("%WS 00:60:00");
    send_text("%WS 00:00:60");
    send_text("%WQ");
    // A zero byte is stored like any other; here it is an unknown command.
    cmd = text_bytes("%W");
    cmd.push_back(8'h00);
    send_cmd(cmd);
    cmd = text_bytes("%W");
    cmd.push_back(8'hFF);
    send_cmd(cmd);
    // Overlong commands fail on length, or on the prefix if that is bad too.
    send_text("%WS 12:34:56789");
    send_text("#WS 12:34:56789");
    // A tick in the middle of a command leaves the collected bytes alone.
    cmd = text_bytes(set_text(12, 34, 56));
    foreach (cmd[i]) begin
      if (i == POS_S10) send_tick();
      send_beat('{operation: OP_CHAR, char_byte: cmd[i], last_char: (i == cmd.size() - 1)});
    end
    send_tick();
  endtask

  // Mostly well-formed commands with random content, some damaged or resized
  // ones, some pure noise, and runs of ticks in between.
  task automatic test_random_commands(input int unsigned count, input bit with_idling);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    byte_q_t     cmd;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      // Idling comes and goes so that some stretches run at full rate.
      idling_on = with_idling && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        cmd = text_bytes(set_text(field_value(23), field_value(59), field_value(59)));
      end else if (pick < 50) begin
        cmd = text_bytes("%WR");
      end else if (pick < 58) begin
        cmd = text_bytes("%WT");
      end else if (pick < 72) begin
        // One damaged byte anywhere in a set command.
        cmd = text_bytes(set_text(field_value(23), field_value(59), field_value(59)));
        cmd[$urandom_range(0, LEN_SET - 1)] = 8'($urandom());
      end else if (pick < 80) begin
        // Digits that parse but may lie beyond the limits.
        cmd = text_bytes(set_text($urandom_range(0, 99), $urandom_range(0, 99),
                                  $urandom_range(0, 99)));
      end else if (pick < 90) begin
        // A known command cut short or padded to a random length.
        case ($urandom_range(0, 2))
          0:       cmd = text_bytes(set_text(12, 34, 56));
          1:       cmd = text_bytes("%WR");
          default: cmd = text_bytes("%WT");
        endcase
        n = $urandom_range(1, 15);
        while (cmd.size() > n) void'(cmd.pop_back());
        while (cmd.size() < n) cmd.push_back(8'($urandom()));
      end else begin
        // Noise, sometimes behind a valid prefix.
        cmd = ($urandom_range(0, 1) == 0) ? text_bytes("%W") : text_bytes("");
        n   = $urandom_range(1, 15);
        while (cmd.size() < n) cmd.push_back(8'($urandom()));
      end
      send_cmd(cmd, 1'b1);
      // Mostly short tick runs; now and then a long one may cross a minute.
      send_ticks(($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall, result checking and the watchdog
  // --------------------------------------------------------------------------

  // Random stall bursts while idling is on.
  initial begin
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic string readout_text(input wcct_out_t r);
    return $sformatf("kind=%0d code=%0d time=%0d:%0d:%0d", r.result_kind, r.error_code,
                     r.hours_out, r.minutes_out, r.seconds_out);
  endfunction

  // Each result beat is matched against the oldest owed result.
  always @(posedge clk) begin
    wcct_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (readouts_due.size() == 0) begin
        if (fail_count < 10)
          $display("[%0t] result with none owed: %s", $realtime, readout_text(out_data));
        fail_count++;
      end else begin
        want = readouts_due.pop_front();
        if (out_data.result_kind !== want.result_kind || out_data.error_code !== want.error_code ||
            out_data.hours_out !== want.hours_out || out_data.minutes_out !== want.minutes_out ||
            out_data.seconds_out !== want.seconds_out) begin
          if (fail_count < 10)
            $display("[%0t] result mismatch: expected %s, got %s", $realtime,
                     readout_text(want), readout_text(out_data));
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** wall_clock_command_timekeeper_unit: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    mdl_hours   = '0;
    mdl_minutes = '0;
    mdl_seconds = '0;
    mdl_running = 1'b0;
    cmd_len     = 0;
    foreach (cmd_store[i]) cmd_store[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_stopped_clock();
    test_start_and_wrap();
    test_command_errors();
    test_random_commands(1300, 1'b1);
    // The last stretch runs with no gaps and no stalls at all.
    test_random_commands(350, 1'b0);
    idling_on = 1'b0;
    drain_results();

    if (fail_count == 0) begin
      $display("** wall_clock_command_timekeeper_unit: PASSED **");
    end else begin
      $display("** wall_clock_command_timekeeper_unit: FAILED **");
    end
    $finish;
  end

endmodule
